// File: hw/rtl/ssf_pkg.sv
// Shared types and constants for the safety supervisor: beat layouts,
// configuration register map, request and status codes, counter helpers.
// Standalone; imported by every module of the block.
package ssf_pkg;

   // Event counters wrap at this width (8 to 32)
   localparam int COUNT_BITS = 16;
   localparam int COUNT_OUT_W = 16;

   typedef logic [COUNT_BITS-1:0] cnt_type;

   // Configuration port geometry
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W = 3;

   // Register indexes (byte address is 4 * index)
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMU_TIMEOUT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EMG_TIMEOUT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRACE          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_RECOVER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENT_MASK   = 3'd5;

   // Register reset values
   localparam logic [31:0] RST_MOTION_TIMEOUT = 32'd500;
   localparam logic [31:0] RST_IMU_TIMEOUT    = 32'd500;
   localparam logic [31:0] RST_EMG_TIMEOUT    = 32'd500;
   localparam logic [31:0] RST_GRACE          = 32'd1000;
   localparam logic        RST_AUTO_RECOVER   = 1'b1;
   localparam logic [4:0]  RST_PRESENT_MASK   = 5'd31;

   // Monitor mask bits
   localparam int MASK_IMU       = 0;
   localparam int MASK_EMG       = 1;
   localparam int MASK_MOTION_HB = 2;
   localparam int MASK_IMU_HB    = 3;
   localparam int MASK_EMG_HB    = 4;

   // Request codes
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_TRIGGER = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;
   localparam logic [1:0] ACT_SAFE    = 2'd3;

   // IMU status codes
   localparam logic [2:0] IMU_OK      = 3'd0;
   localparam logic [2:0] IMU_UNINIT  = 3'd1;
   localparam logic [2:0] IMU_TMO     = 3'd2;
   localparam logic [2:0] IMU_BUS_ERR = 3'd3;
   localparam logic [2:0] IMU_FAULT   = 3'd4;

   // EMG status codes
   localparam logic [2:0] EMG_OK      = 3'd0;
   localparam logic [2:0] EMG_UNINIT  = 3'd1;
   localparam logic [2:0] EMG_TMO     = 3'd2;
   localparam logic [2:0] EMG_FAULT   = 3'd3;

   typedef struct packed {
      logic [31:0] motion_timeout_ms;
      logic [31:0] imu_timeout_ms;
      logic [31:0] emg_timeout_ms;
      logic [31:0] grace_ms;
      logic        auto_recover;
      logic [4:0]  present_mask;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now_ms;
      logic [31:0] motion_age_ms;
      logic [31:0] imu_age_ms;
      logic [31:0] emg_age_ms;
      logic [2:0]  imu_status;
      logic [2:0]  emg_status;
   } req_type;

   typedef struct packed {
      logic [2:0]             system_state;
      logic                   state_changed;
      logic                   stop_drive;
      logic                   emergency_event;
      logic                   recovered_event;
      logic                   imu_lost_event;
      logic                   emg_lost_event;
      logic                   clear_refused;
      logic [COUNT_OUT_W-1:0] emergency_count;
      logic [COUNT_OUT_W-1:0] recovery_count;
      logic [COUNT_OUT_W-1:0] stall_count;
      logic [COUNT_OUT_W-1:0] sensor_loss_count;
   } rsp_type;

   // Low bits of a counter as reported, zero-extended when narrower
   function automatic logic [COUNT_OUT_W-1:0] cnt_out(input cnt_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[COUNT_OUT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/ssf_csr.sv
// Configuration register file of the safety supervisor on an APB-style port.
// Depends on ssf_pkg for the register map, reset values and cfg_type.
module ssf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ssf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ssf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ssf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output ssf_pkg::cfg_type           cfg
);
   import ssf_pkg::*;

   cfg_type               cfg_ff;
   logic                  wr_en;
   logic [CSR_IDX_W-1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   // Write the addressed register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_timeout_ms <= RST_MOTION_TIMEOUT;
         cfg_ff.imu_timeout_ms    <= RST_IMU_TIMEOUT;
         cfg_ff.emg_timeout_ms    <= RST_EMG_TIMEOUT;
         cfg_ff.grace_ms          <= RST_GRACE;
         cfg_ff.auto_recover      <= RST_AUTO_RECOVER;
         cfg_ff.present_mask      <= RST_PRESENT_MASK;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MOTION_TIMEOUT: cfg_ff.motion_timeout_ms <= csr_pwdata;
            REG_IMU_TIMEOUT:    cfg_ff.imu_timeout_ms    <= csr_pwdata;
            REG_EMG_TIMEOUT:    cfg_ff.emg_timeout_ms    <= csr_pwdata;
            REG_GRACE:          cfg_ff.grace_ms          <= csr_pwdata;
            REG_AUTO_RECOVER:   cfg_ff.auto_recover      <= csr_pwdata[0];
            REG_PRESENT_MASK:   cfg_ff.present_mask      <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_idx)
         REG_MOTION_TIMEOUT: csr_prdata = cfg_ff.motion_timeout_ms;
         REG_IMU_TIMEOUT:    csr_prdata = cfg_ff.imu_timeout_ms;
         REG_EMG_TIMEOUT:    csr_prdata = cfg_ff.emg_timeout_ms;
         REG_GRACE:          csr_prdata = cfg_ff.grace_ms;
         REG_AUTO_RECOVER:   csr_prdata = 32'(cfg_ff.auto_recover);
         REG_PRESENT_MASK:   csr_prdata = 32'(cfg_ff.present_mask);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/safety_supervisor_fsm.sv
// Safety supervisor top level: request register, state update and result register.
// Depends on ssf_pkg and ssf_csr.
//
// The supervisor takes one request beat per clock unless req_stall holds it off,
// and returns exactly one result beat per request. A beat first lands in the
// request register; then the tick/trigger/clear/safe-mode logic reads it together
// with the supervisor state, updates the state and loads the result register. The
// state update is combinational from the state registers, so back-to-back
// requests each see the state left by the previous one, and the sustained rate is
// one beat per cycle while the result side does not stall. A stall on the result
// side backs up into the request register and then onto req_stall. Configuration
// registers are to be written only while no request is in flight.
module safety_supervisor_fsm (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ssf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ssf_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ssf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ssf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ssf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ssf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_ACTIVE = 3'd1,
      ST_ERROR  = 3'd2,
      ST_SAFE   = 3'd3,
      ST_ESTOP  = 3'd4
   } state_type;

   cfg_type     cfg;

   // Request stage
   logic        req_valid_ff;
   req_type     req_ff;
   // Result stage
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   // Supervisor state
   state_type   state_ff, state_in;
   logic [31:0] entry_ff, entry_in;
   logic        imu_was_ok_ff, imu_was_ok_in;
   logic        emg_was_ok_ff, emg_was_ok_in;
   cnt_type     emerg_cnt_ff, emerg_cnt_in;
   cnt_type     recov_cnt_ff, recov_cnt_in;
   cnt_type     stall_cnt_ff, stall_cnt_in;
   cnt_type     loss_cnt_ff, loss_cnt_in;
   rsp_type     rsp_in;

   logic        rsp_free;
   logic        advance;
   logic        idle_or_active;
   logic        motion_stale, imu_stale, emg_stale;
   logic        tick_imu_ok, tick_emg_ok;
   logic        clr_imu_ok, clr_emg_ok;
   logic        grace_over;
   logic        stop_ev, emerg_ev, recov_ev, imu_lost, emg_lost, refused;

   ssf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: result register frees when empty or taken
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Heartbeat checks; a stale motion heartbeat masks the other two
   assign idle_or_active = (state_ff == ST_IDLE) || (state_ff == ST_ACTIVE);
   assign motion_stale = cfg.present_mask[MASK_MOTION_HB] &&
                         (req_ff.motion_age_ms > cfg.motion_timeout_ms);
   assign imu_stale = !motion_stale && cfg.present_mask[MASK_IMU_HB] &&
                      (req_ff.imu_age_ms > cfg.imu_timeout_ms);
   assign emg_stale = !motion_stale && cfg.present_mask[MASK_EMG_HB] &&
                      (req_ff.emg_age_ms > cfg.emg_timeout_ms);
   assign grace_over = (req_ff.now_ms - entry_ff) > cfg.grace_ms;

   // Sensor health as seen by a tick and by a clear
   always_comb begin
      tick_imu_ok = !cfg.present_mask[MASK_IMU] ||
                    !(req_ff.imu_status inside {IMU_TMO, IMU_BUS_ERR, IMU_FAULT});
      tick_emg_ok = !cfg.present_mask[MASK_EMG] ||
                    !(req_ff.emg_status inside {EMG_TMO, EMG_FAULT});
      clr_imu_ok  = !cfg.present_mask[MASK_IMU] ||
                    (req_ff.imu_status inside {IMU_OK, IMU_UNINIT});
      clr_emg_ok  = !cfg.present_mask[MASK_EMG] ||
                    (req_ff.emg_status inside {EMG_OK, EMG_UNINIT});
   end

   // Next state and result for the beat in the request register
   always_comb begin
      state_in      = state_ff;
      entry_in      = entry_ff;
      imu_was_ok_in = imu_was_ok_ff;
      emg_was_ok_in = emg_was_ok_ff;
      emerg_cnt_in  = emerg_cnt_ff;
      recov_cnt_in  = recov_cnt_ff;
      stall_cnt_in  = stall_cnt_ff;
      loss_cnt_in   = loss_cnt_ff;
      stop_ev       = 1'b0;
      emerg_ev      = 1'b0;
      recov_ev      = 1'b0;
      imu_lost      = 1'b0;
      emg_lost      = 1'b0;
      refused       = 1'b0;
      case (req_ff.action)
         ACT_TICK: begin
            // Stale motion heartbeat: count and force emergency stop
            if (motion_stale) begin
               stall_cnt_in = stall_cnt_in + cnt_type'(1);
               if (state_ff != ST_ESTOP) begin
                  emerg_cnt_in = emerg_cnt_ff + cnt_type'(1);
                  state_in     = ST_ESTOP;
                  emerg_ev     = 1'b1;
                  stop_ev      = 1'b1;
               end
            end
            // Stale IMU or EMG heartbeat: count, drop into error from idle or active
            stall_cnt_in = stall_cnt_in + cnt_type'(imu_stale) + cnt_type'(emg_stale);
            if ((imu_stale || emg_stale) && idle_or_active) begin
               state_in = ST_ERROR;
               entry_in = req_ff.now_ms;
            end
            // Sensor loss edges
            if (cfg.present_mask[MASK_IMU]) begin
               imu_lost      = imu_was_ok_ff && !tick_imu_ok;
               imu_was_ok_in = tick_imu_ok;
            end
            if (cfg.present_mask[MASK_EMG]) begin
               emg_lost      = emg_was_ok_ff && !tick_emg_ok;
               emg_was_ok_in = tick_emg_ok;
            end
            loss_cnt_in = loss_cnt_ff + cnt_type'(imu_lost) + cnt_type'(emg_lost);
            // Both sensors down: force safe mode
            if (!tick_imu_ok && !tick_emg_ok &&
                (state_in == ST_IDLE || state_in == ST_ACTIVE)) begin
               state_in = ST_SAFE;
               stop_ev  = 1'b1;
            end
            // Automatic recovery once the grace period has passed
            if (state_ff == ST_ERROR && state_in == ST_ERROR && tick_imu_ok &&
                tick_emg_ok && cfg.auto_recover && grace_over) begin
               recov_cnt_in = recov_cnt_ff + cnt_type'(1);
               state_in     = ST_IDLE;
               recov_ev     = 1'b1;
            end
         end
         ACT_TRIGGER: begin
            if (state_ff != ST_ESTOP) begin
               emerg_cnt_in = emerg_cnt_ff + cnt_type'(1);
               state_in     = ST_ESTOP;
               emerg_ev     = 1'b1;
               stop_ev      = 1'b1;
            end
         end
         ACT_CLEAR: begin
            if (state_ff == ST_ESTOP || state_ff == ST_SAFE) begin
               if (!clr_imu_ok && !clr_emg_ok) begin
                  refused = 1'b1;
               end else begin
                  recov_cnt_in = recov_cnt_ff + cnt_type'(1);
                  state_in     = ST_IDLE;
                  recov_ev     = 1'b1;
               end
            end
         end
         ACT_SAFE: begin
            state_in = ST_SAFE;
            stop_ev  = 1'b1;
         end
         default: ;
      endcase

      rsp_in.system_state      = state_in;
      rsp_in.state_changed     = (state_in != state_ff);
      rsp_in.stop_drive        = stop_ev;
      rsp_in.emergency_event   = emerg_ev;
      rsp_in.recovered_event   = recov_ev;
      rsp_in.imu_lost_event    = imu_lost;
      rsp_in.emg_lost_event    = emg_lost;
      rsp_in.clear_refused     = refused;
      rsp_in.emergency_count   = cnt_out(emerg_cnt_in);
      rsp_in.recovery_count    = cnt_out(recov_cnt_in);
      rsp_in.stall_count       = cnt_out(stall_cnt_in);
      rsp_in.sensor_loss_count = cnt_out(loss_cnt_in);
   end

   // Hold state, request register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= ST_IDLE;
         entry_ff      <= '0;
         imu_was_ok_ff <= 1'b1;
         emg_was_ok_ff <= 1'b1;
         emerg_cnt_ff  <= '0;
         recov_cnt_ff  <= '0;
         stall_cnt_ff  <= '0;
         loss_cnt_ff   <= '0;
      end else begin
         // Take a new request beat whenever the request register moves on
         if (!req_stall) begin
            req_valid_ff <= req_valid;
            if (req_valid) begin
               req_ff <= req_data;
            end
         end
         // Advance the state and load the result
         if (advance) begin
            state_ff      <= state_in;
            entry_ff      <= entry_in;
            imu_was_ok_ff <= imu_was_ok_in;
            emg_was_ok_ff <= emg_was_ok_in;
            emerg_cnt_ff  <= emerg_cnt_in;
            recov_cnt_ff  <= recov_cnt_in;
            stall_cnt_ff  <= stall_cnt_in;
            loss_cnt_ff   <= loss_cnt_in;
            rsp_ff        <= rsp_in;
         end
         if (rsp_free) begin
            rsp_valid_ff <= advance;
         end
      end
   end

endmodule
